@@ src/hlm_pkg.sv @@
// ----------------------------------------------------------------------------
// hlm_pkg
// Shared types, codes and byte-lane helpers of the horizontal line mirror.
// ----------------------------------------------------------------------------
package hlm_pkg;

   localparam int unsigned DEF_MAX_LINE_WORDS = 4096;

   localparam int PIXEL_W    = 32;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 13;
   localparam int BPP_W      = 3;
   localparam int ORDER_W    = 2;
   localparam int WIDTH_W    = 13;

   localparam logic [BPP_W-1:0]   BPP_RESET   = 3'd1;
   localparam logic [ORDER_W-1:0] ORDER_PLAIN = 2'd0;
   localparam logic [ORDER_W-1:0] ORDER_UYVY  = 2'd1;
   localparam logic [ORDER_W-1:0] ORDER_YUY2  = 2'd2;
   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd640;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_BYTES_PER_PIXEL = 2'd0,
      CSR_PACKED_ORDER    = 2'd1,
      CSR_LINE_WIDTH      = 2'd2
   } csr_addr_type;

   typedef enum logic [2:0] {
      SWZ_8,
      SWZ_16,
      SWZ_24,
      SWZ_32,
      SWZ_UYVY,
      SWZ_YUY2
   } swz_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               line_end;
   } rsp_item_type;

   function automatic swz_type swz_select(input logic [BPP_W-1:0] bpp,
                                          input logic [ORDER_W-1:0] order);
      swz_type m;
      case (bpp)
         3'd0, 3'd1: m = SWZ_8;
         3'd2: begin
            if (order == ORDER_UYVY)      m = SWZ_UYVY;
            else if (order == ORDER_YUY2) m = SWZ_YUY2;
            else                          m = SWZ_16;
         end
         3'd3:    m = SWZ_24;
         default: m = SWZ_32;
      endcase
      return m;
   endfunction

   function automatic logic [PIXEL_W-1:0] swizzle(input swz_type m,
                                                  input logic [PIXEL_W-1:0] w);
      logic [PIXEL_W-1:0] r;
      case (m)
         SWZ_8:    r = {24'd0, w[7:0]};
         SWZ_16:   r = {16'd0, w[15:0]};
         SWZ_24:   r = {8'd0, w[23:0]};
         SWZ_UYVY: r = {w[15:8], w[23:16], w[31:24], w[7:0]};
         SWZ_YUY2: r = {w[31:24], w[7:0], w[15:8], w[23:16]};
         default:  r = w;
      endcase
      return r;
   endfunction

endpackage

@@ src/hlm_if.sv @@
// ----------------------------------------------------------------------------
// hlm_if
// Valid/ready channels of the horizontal line mirror: pixel input, mirrored
// output and register write.
// ----------------------------------------------------------------------------
interface hlm_req_if import hlm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_in;
   logic               flush;
   modport source (output valid, output pixel_in, output flush, input ready);
   modport sink   (input valid, input pixel_in, input flush, output ready);
endinterface

interface hlm_rsp_if import hlm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_out;
   logic               line_end;
   modport source (output valid, output pixel_out, output line_end, input ready);
   modport sink   (input valid, input pixel_out, input line_end, output ready);
endinterface

interface hlm_csr_if import hlm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output addr, output data, input ready);
   modport sink   (input valid, input addr, input data, output ready);
endinterface

@@ src/hlm_line_ram.sv @@
// ----------------------------------------------------------------------------
// hlm_line_ram
// Line bank storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hlm_line_ram import hlm_pkg::*; #(
   parameter int unsigned DEPTH = 2 * DEF_MAX_LINE_WORDS,
   parameter int unsigned AW    = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [PIXEL_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output logic [PIXEL_W-1:0] rd_data
);

   logic [PIXEL_W-1:0] mem [DEPTH];
   logic [PIXEL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/horizontal_line_mirror.sv @@
// A result passes the read stage and the output queue after the item that reads
// it is accepted. Throughput: one item per cycle while the input is ready; an
// item costs at most one bank write and one bank read on the two ports of the
// line memory, and a three-entry output queue keeps the input open while the
// output stalls. Reset clears positions, bank select, pending flag, queue and
// registers; the line memory is not cleared and is read only once written.
// ----------------------------------------------------------------------------
// horizontal_line_mirror
// Mirrors video lines left to right through two alternating line banks.
// ----------------------------------------------------------------------------
module horizontal_line_mirror import hlm_pkg::*; #(
   parameter int unsigned MAX_LINE_WORDS = DEF_MAX_LINE_WORDS
) (
   input logic clock,
   input logic reset,
   hlm_req_if.sink   req_ch,
   hlm_rsp_if.source rsp_ch,
   hlm_csr_if.sink   csr_ch
);

   localparam int unsigned PW    = $clog2(MAX_LINE_WORDS);
   localparam int unsigned CW    = $clog2(MAX_LINE_WORDS + 1);
   localparam int unsigned WW    = (CW > WIDTH_W) ? CW : WIDTH_W;
   localparam int unsigned DEPTH = 2 * MAX_LINE_WORDS;
   localparam int unsigned AW    = $clog2(DEPTH);
   localparam int unsigned QD    = 3;

   // configuration
   logic [BPP_W-1:0]   bpp_ff;
   logic [ORDER_W-1:0] order_ff;
   logic [WIDTH_W-1:0] width_ff;

   // line control
   logic [PW-1:0] wp_ff, wp_in;
   logic [PW-1:0] rp_ff, rp_in;
   logic          bank_ff, bank_in;
   logic          pend_ff, pend_in;

   // read stage
   logic    s1_valid_ff;
   logic    s1_last_ff;
   swz_type s1_mode_ff;

   // output queue
   rsp_item_type   q_ff [QD];
   logic [1:0]     q_wr_ff, q_rd_ff, q_cnt_ff;
   logic [1:0]     q_cnt_in;

   swz_type          mode;
   logic             packed_mode;
   logic [WIDTH_W-1:0] pix_words;
   logic [WW-1:0]    pix_words_ext;
   logic [CW-1:0]    words;
   logic             accept, rd_fire, wr_fire, rd_last, q_push, q_pop;
   logic [CW-1:0]    rp_ext, wp_ext, wr_next;
   logic [PW-1:0]    rd_idx, wr_pos;
   logic [AW-1:0]    rd_addr, wr_addr;
   logic [PIXEL_W-1:0] ram_q;

   assign mode        = swz_select(bpp_ff, order_ff);
   assign packed_mode = (mode == SWZ_UYVY) || (mode == SWZ_YUY2);
   assign pix_words   = packed_mode ? {1'b0, width_ff[WIDTH_W-1:1]} : width_ff;
   assign pix_words_ext = WW'(pix_words);
   assign words = (pix_words_ext > WW'(MAX_LINE_WORDS)) ? CW'(MAX_LINE_WORDS)
                                                         : CW'(pix_words_ext);

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff   <= BPP_RESET;
         order_ff <= ORDER_PLAIN;
         width_ff <= WIDTH_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.addr)
            CSR_BYTES_PER_PIXEL: bpp_ff   <= csr_ch.data[BPP_W-1:0];
            CSR_PACKED_ORDER:    order_ff <= csr_ch.data[ORDER_W-1:0];
            CSR_LINE_WIDTH:      width_ff <= csr_ch.data[WIDTH_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_ch.ready = ({1'b0, q_cnt_ff} + {2'b00, s1_valid_ff}) < 3'(QD);
   assign accept       = req_ch.valid && req_ch.ready;
   assign rd_fire      = accept && pend_ff;
   assign wr_fire      = accept && !req_ch.flush && (words != '0);

   always_comb begin
      rp_ext  = CW'(rp_ff);
      wp_ext  = CW'(wp_ff);
      rd_idx  = (rp_ext < words) ? PW'(words - rp_ext - CW'(1)) : '0;
      rd_last = ({1'b0, rp_ext} + (CW+1)'(1)) >= {1'b0, words};
      wr_pos  = (wp_ext < words) ? wp_ff : PW'(words - CW'(1));
      wr_next = CW'(wr_pos) + CW'(1);
      rd_addr = (bank_ff ? AW'(0) : AW'(MAX_LINE_WORDS)) + AW'(rd_idx);
      wr_addr = (bank_ff ? AW'(MAX_LINE_WORDS) : AW'(0)) + AW'(wr_pos);

      wp_in   = wp_ff;
      rp_in   = rp_ff;
      bank_in = bank_ff;
      pend_in = pend_ff;
      if (rd_fire) begin
         if (rd_last) begin
            pend_in = 1'b0;
            rp_in   = '0;
         end else begin
            rp_in = rp_ff + PW'(1);
         end
      end
      if (wr_fire) begin
         if (wr_next >= words) begin
            bank_in = ~bank_ff;
            wp_in   = '0;
            pend_in = 1'b1;
            rp_in   = '0;
         end else begin
            wp_in = PW'(wr_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         rp_ff       <= '0;
         bank_ff     <= 1'b0;
         pend_ff     <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         wp_ff       <= wp_in;
         rp_ff       <= rp_in;
         bank_ff     <= bank_in;
         pend_ff     <= pend_in;
         s1_valid_ff <= rd_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_fire) begin
         s1_last_ff <= rd_last;
         s1_mode_ff <= mode;
      end
   end

   hlm_line_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_fire),
      .wr_addr (wr_addr),
      .wr_data (req_ch.pixel_in),
      .rd_en   (rd_fire),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign q_push = s1_valid_ff;
   assign q_pop  = rsp_ch.valid && rsp_ch.ready;
   assign q_cnt_in = q_cnt_ff + {1'b0, q_push} - {1'b0, q_pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff  <= '0;
         q_rd_ff  <= '0;
         q_cnt_ff <= '0;
      end else begin
         q_cnt_ff <= q_cnt_in;
         if (q_push) begin
            q_wr_ff <= (q_wr_ff == 2'(QD - 1)) ? 2'd0 : q_wr_ff + 2'd1;
         end
         if (q_pop) begin
            q_rd_ff <= (q_rd_ff == 2'(QD - 1)) ? 2'd0 : q_rd_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         q_ff[q_wr_ff] <= '{pixel: swizzle(s1_mode_ff, ram_q), line_end: s1_last_ff};
      end
   end

   assign rsp_ch.valid     = (q_cnt_ff != '0);
   assign rsp_ch.pixel_out = q_ff[q_rd_ff].pixel;
   assign rsp_ch.line_end  = q_ff[q_rd_ff].line_end;

endmodule

@@ src/hlm_checker.sv @@
// ----------------------------------------------------------------------------
// hlm_checker
// Port-level checks of the horizontal line mirror, bound to the top level.
// ----------------------------------------------------------------------------
module hlm_checker import hlm_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [PIXEL_W-1:0] rsp_pixel_out,
   input logic               rsp_line_end
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_pixel_out) && $stable(rsp_line_end))
      else $error("result item changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item present after reset");

   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) && !$past(reset) && !$past(reset, 2)
         |-> $past(req_valid && req_ready, 2))
      else $error("result item without an accepted item two cycles before");

endmodule

bind horizontal_line_mirror hlm_checker u_hlm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_pixel_out (rsp_ch.pixel_out),
   .rsp_line_end  (rsp_ch.line_end)
);
